// File: design/krt_pkg.sv
// Shared constants and types for the keyed record table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int LOW_W  = 64;
	localparam int HIGH_W = 8;
	localparam int WORD_W = LOW_W + HIGH_W;
	localparam int FILL_W = 7;
	localparam int CMD_W  = 2;

	// Operation codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_item;   // capture the input item, clear the scan index
		logic idx_inc;     // advance the scan index
		logic rd_en;       // read both stores
		logic rd_next;     // read at index + 1 instead of index
		logic wr_append;   // write the held item at the fill count
		logic wr_shift;    // write the last read entry at the index
		logic cnt_inc;
		logic cnt_dec;
		logic res_load;    // load the result register
		logic res_ok;
		logic res_found;   // result carries the read value
	} ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             scan_end;  // index has reached the fill count
		logic             idx_last;  // index is the last held entry
		logic             key_hit;   // read key equals the held key
		logic             out_free;  // result register can take a new item
	} sts_t;

endpackage

`default_nettype wire

// File: design/keyed_record_table_unit.sv
// Keyed record table: top level joining controller and datapath.
// Depends on krt_pkg, krt_ctrl and krt_dpath.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one operation per item:
//   cmd (append, delete, find), a 72-bit key split into key_low/key_high
//   and, for append, a 72-bit value. The output channel (out_valid/
//   out_ready) returns one result item per operation: ok, the found value
//   (zero unless a find matched) and the fill level after the operation.
//   Items are worked one at a time; in_ready is high only while the
//   controller is idle, but a result may still wait in the output
//   register while the next item is taken.
//   An append or an unused code goes from dispatch straight to the finish
//   state; a find or delete scans the held entries in turn, reading the
//   stores and then comparing the key, and a delete moves each later entry
//   down by one store read and one write before the fill count drops. The
//   next item is taken once the result is loaded and the controller idles.
//   Reset clears the fill count and the controller; store contents are
//   not cleared, as only entries below the fill count are ever read.
//   If the receiver stalls, the finished result holds in the output
//   register and a following item waits in its final state until the
//   register frees up.
`timescale 1ns / 1ps
`default_nettype none

module keyed_record_table_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [krt_pkg::CMD_W-1:0]   cmd,
	input  wire logic [krt_pkg::LOW_W-1:0]   key_low,
	input  wire logic [krt_pkg::HIGH_W-1:0]  key_high,
	input  wire logic [krt_pkg::LOW_W-1:0]   value_low,
	input  wire logic [krt_pkg::HIGH_W-1:0]  value_high,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             ok,
	output logic [krt_pkg::LOW_W-1:0]        found_low,
	output logic [krt_pkg::HIGH_W-1:0]       found_high,
	output logic [krt_pkg::FILL_W-1:0]       fill_level
);

	krt_pkg::ctl_t ctl;
	krt_pkg::sts_t sts;

	krt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	krt_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (cmd),
		.key_low    (key_low),
		.key_high   (key_high),
		.value_low  (value_low),
		.value_high (value_high),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.found_low  (found_low),
		.found_high (found_high),
		.fill_level (fill_level)
	);

endmodule

`default_nettype wire

// File: design/krt_dpath.sv
// Datapath of the keyed record table: item holding registers, key and
// value stores, fill count, scan index and result register. Uses krt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module krt_dpath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire krt_pkg::ctl_t               ctl,
	output krt_pkg::sts_t                    sts,
	input  wire logic [krt_pkg::CMD_W-1:0]   cmd,
	input  wire logic [krt_pkg::LOW_W-1:0]   key_low,
	input  wire logic [krt_pkg::HIGH_W-1:0]  key_high,
	input  wire logic [krt_pkg::LOW_W-1:0]   value_low,
	input  wire logic [krt_pkg::HIGH_W-1:0]  value_high,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             ok,
	output logic [krt_pkg::LOW_W-1:0]        found_low,
	output logic [krt_pkg::HIGH_W-1:0]       found_high,
	output logic [krt_pkg::FILL_W-1:0]       fill_level
);

	// Stores
	logic [krt_pkg::WORD_W-1:0] key_mem [krt_pkg::TABLE_DEPTH];
	logic [krt_pkg::WORD_W-1:0] val_mem [krt_pkg::TABLE_DEPTH];

	logic [krt_pkg::CMD_W-1:0]  cmd_q;
	logic [krt_pkg::WORD_W-1:0] key_q;
	logic [krt_pkg::WORD_W-1:0] val_q;
	logic [krt_pkg::CNT_W-1:0]  count_q;
	logic [krt_pkg::CNT_W-1:0]  idx_q;
	logic [krt_pkg::WORD_W-1:0] key_rd_q;
	logic [krt_pkg::WORD_W-1:0] val_rd_q;
	logic                       out_valid_q;
	logic                       ok_q;
	logic [krt_pkg::WORD_W-1:0] found_q;
	logic [krt_pkg::FILL_W-1:0] fill_q;

	logic [krt_pkg::CNT_W:0]    idx_plus1;
	logic [krt_pkg::IDX_W-1:0]  rd_addr;
	logic [krt_pkg::IDX_W-1:0]  wr_addr;
	logic [krt_pkg::WORD_W-1:0] wr_key;
	logic [krt_pkg::WORD_W-1:0] wr_val;
	logic                       wr_en;

	assign idx_plus1 = {1'b0, idx_q} + (krt_pkg::CNT_W + 1)'(1);

	// Address and write data selection
	always_comb begin
		rd_addr = ctl.rd_next ? idx_plus1[krt_pkg::IDX_W-1:0] : idx_q[krt_pkg::IDX_W-1:0];
		wr_en   = ctl.wr_append | ctl.wr_shift;
		if (ctl.wr_append) begin
			wr_addr = count_q[krt_pkg::IDX_W-1:0];
			wr_key  = key_q;
			wr_val  = val_q;
		end else begin
			wr_addr = idx_q[krt_pkg::IDX_W-1:0];
			wr_key  = key_rd_q;
			wr_val  = val_rd_q;
		end
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
		if (ctl.rd_en) begin
			key_rd_q <= key_mem[rd_addr];
			val_rd_q <= val_mem[rd_addr];
		end
	end

	// Held item
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q <= cmd;
			key_q <= {key_high, key_low};
			val_q <= {value_high, value_low};
		end
	end

	// Fill count and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (ctl.cnt_inc)
				count_q <= count_q + krt_pkg::CNT_W'(1);
			else if (ctl.cnt_dec)
				count_q <= count_q - krt_pkg::CNT_W'(1);
			if (ctl.load_item)
				idx_q <= '0;
			else if (ctl.idx_inc)
				idx_q <= idx_plus1[krt_pkg::CNT_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.res_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			ok_q    <= ctl.res_ok;
			found_q <= ctl.res_found ? val_rd_q : '0;
			fill_q  <= krt_pkg::FILL_W'(count_q);
		end
	end

	// Status
	always_comb begin
		sts.cmd      = cmd_q;
		sts.full     = (count_q >= krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH));
		sts.scan_end = (idx_q >= count_q);
		sts.idx_last = (idx_plus1 >= {1'b0, count_q});
		sts.key_hit  = (key_rd_q == key_q);
		sts.out_free = ~out_valid_q | out_ready;
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign found_low  = found_q[krt_pkg::LOW_W-1:0];
	assign found_high = found_q[krt_pkg::WORD_W-1:krt_pkg::LOW_W];
	assign fill_level = fill_q;

endmodule

`default_nettype wire

// File: design/krt_ctrl.sv
// Controller of the keyed record table: sequences append, scan and
// compaction over the datapath. Uses krt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module krt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire krt_pkg::sts_t sts,
	output krt_pkg::ctl_t      ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ok_q;
	logic   ok_d;
	logic   found_q;
	logic   found_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		found_d = found_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load_item = 1'b1;
					ok_d          = 1'b0;
					found_d       = 1'b0;
					state_d       = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.cmd == krt_pkg::CMD_APPEND) begin
					if (!sts.full) begin
						ctl.wr_append = 1'b1;
						ctl.cnt_inc   = 1'b1;
						ok_d          = 1'b1;
					end
					state_d = ST_FINISH;
				end else if (sts.cmd == krt_pkg::CMD_DELETE || sts.cmd == krt_pkg::CMD_FIND) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SCAN_RD: begin
				if (sts.scan_end) begin
					state_d = ST_FINISH;
				end else begin
					ctl.rd_en = 1'b1;
					state_d   = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				if (!sts.key_hit) begin
					ctl.idx_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end else if (sts.cmd == krt_pkg::CMD_FIND) begin
					ok_d    = 1'b1;
					found_d = 1'b1;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SHIFT_RD;
				end
			end
			ST_SHIFT_RD: begin
				if (sts.idx_last) begin
					ctl.cnt_dec = 1'b1;
					ok_d        = 1'b1;
					state_d     = ST_FINISH;
				end else begin
					ctl.rd_en   = 1'b1;
					ctl.rd_next = 1'b1;
					state_d     = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				ctl.wr_shift = 1'b1;
				ctl.idx_inc  = 1'b1;
				state_d      = ST_SHIFT_RD;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					ctl.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		ctl.res_ok    = ok_q;
		ctl.res_found = found_q;
	end

	// State and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ok_q    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			found_q <= found_d;
		end
	end

endmodule

`default_nettype wire

// File: design/krt_checker.sv
// Port-level checks for the keyed record table, bound to the top level.
// Depends on krt_pkg and keyed_record_table_unit.
`timescale 1ns / 1ps
`default_nettype none

module krt_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       ok,
	input wire logic [krt_pkg::LOW_W-1:0]  found_low,
	input wire logic [krt_pkg::HIGH_W-1:0] found_high,
	input wire logic [krt_pkg::FILL_W-1:0] fill_level
);

	// One item at a time: an accepted item closes the input channel
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an item was accepted");

	// Fill level never exceeds the table depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_level <= krt_pkg::FILL_W'(krt_pkg::TABLE_DEPTH))
		else $error("fill_level beyond table depth");

	// A failed operation returns no value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> found_low == '0 && found_high == '0)
		else $error("nonzero found value on a failed operation");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(found_low)
			&& $stable(found_high) && $stable(fill_level))
		else $error("result changed while stalled");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.ok         (ok),
	.found_low  (found_low),
	.found_high (found_high),
	.fill_level (fill_level)
);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for keyed_record_table_unit: append, delete and find traffic
// with random idling on both channels, checked against a table model kept in a class.
// Depends on krt_pkg and keyed_record_table_unit.
`timescale 1ns / 1ps

typedef logic [krt_pkg::WORD_W-1:0] rec_word_t;

typedef struct packed {
	logic                       ok;
	rec_word_t                  found;
	logic [krt_pkg::FILL_W-1:0] fill;
} table_reply_t;

// Keeps its own copy of the table, works out the reply of every accepted item
// and compares the replies of the block against them in order.
class table_reply_checker;
	rec_word_t    key_mem [krt_pkg::TABLE_DEPTH];
	rec_word_t    val_mem [krt_pkg::TABLE_DEPTH];
	int unsigned  held;
	table_reply_t replies_due [$];
	int unsigned  errors;
	int unsigned  requests;
	int unsigned  compared;
	int unsigned  find_hits;
	int unsigned  delete_hits;
	int unsigned  full_refusals;
	int unsigned  peak_fill;

	function new();
		held          = 0;
		errors        = 0;
		requests      = 0;
		compared      = 0;
		find_hits     = 0;
		delete_hits   = 0;
		full_refusals = 0;
		peak_fill     = 0;
	endfunction

	function int unsigned pending();
		return replies_due.size();
	endfunction

	// Lowest index holding the key, or -1
	function int first_slot(rec_word_t k);
		for (int i = 0; i < int'(held); i++) begin
			if (key_mem[i] == k)
				return i;
		end
		return -1;
	endfunction

	// Apply one accepted item to the table and queue its reply
	function void log_request(logic [krt_pkg::CMD_W-1:0] op, rec_word_t k, rec_word_t v);
		table_reply_t want;
		int           slot;
		want = '0;
		requests++;
		case (op)
		krt_pkg::CMD_APPEND: begin
			if (held < krt_pkg::TABLE_DEPTH) begin
				key_mem[held] = k;
				val_mem[held] = v;
				held++;
				want.ok = 1'b1;
			end else begin
				full_refusals++;
			end
		end
		krt_pkg::CMD_DELETE: begin
			slot = first_slot(k);
			if (slot >= 0) begin
				// close the gap, later records keep their order
				for (int j = slot; j + 1 < int'(held); j++) begin
					key_mem[j] = key_mem[j + 1];
					val_mem[j] = val_mem[j + 1];
				end
				held--;
				want.ok = 1'b1;
				delete_hits++;
			end
		end
		krt_pkg::CMD_FIND: begin
			slot = first_slot(k);
			if (slot >= 0) begin
				want.ok    = 1'b1;
				want.found = val_mem[slot];
				find_hits++;
			end
		end
		default: ;  // spare code: nothing changes
		endcase
		want.fill = krt_pkg::FILL_W'(held);
		if (held > peak_fill)
			peak_fill = held;
		replies_due.push_back(want);
	endfunction

	// Compare one reply of the block with the oldest one due
	function void match_reply(logic ok, logic [krt_pkg::LOW_W-1:0] flo,
			logic [krt_pkg::HIGH_W-1:0] fhi, logic [krt_pkg::FILL_W-1:0] fill);
		table_reply_t want;
		if (replies_due.size() == 0) begin
			$error("reply with none due: ok=%0d found=%h_%h fill_level=%0d", ok, fhi, flo, fill);
			errors++;
			return;
		end
		want = replies_due.pop_front();
		compared++;
		if (ok !== want.ok) begin
			$error("ok: expected %0d, got %0d", want.ok, ok);
			errors++;
		end
		if (flo !== want.found[krt_pkg::LOW_W-1:0]) begin
			$error("found_low: expected %h, got %h", want.found[krt_pkg::LOW_W-1:0], flo);
			errors++;
		end
		if (fhi !== want.found[krt_pkg::WORD_W-1:krt_pkg::LOW_W]) begin
			$error("found_high: expected %h, got %h",
				want.found[krt_pkg::WORD_W-1:krt_pkg::LOW_W], fhi);
			errors++;
		end
		if (fill !== want.fill) begin
			$error("fill_level: expected %0d, got %0d", want.fill, fill);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import krt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;
	localparam int              KEY_POOL    = 12;
	localparam int              PER_PHASE   = 400;
	localparam int              CYCLE_LIMIT = 1000000;
	localparam int              SETTLE      = 2 * TABLE_DEPTH + 16;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic [CMD_W-1:0]    cmd        = '0;
	logic [LOW_W-1:0]    key_low    = '0;
	logic [HIGH_W-1:0]   key_high   = '0;
	logic [LOW_W-1:0]    value_low  = '0;
	logic [HIGH_W-1:0]   value_high = '0;
	logic                out_ready  = 1'b0;
	logic                in_ready;
	logic                out_valid;
	logic                ok;
	logic [LOW_W-1:0]    found_low;
	logic [HIGH_W-1:0]   found_high;
	logic [FILL_W-1:0]   fill_level;

	int unsigned         cycle_count    = 0;
	int unsigned         send_idle_pct  = 0;
	int unsigned         recv_stall_pct = 0;
	bit                  growing        = 1'b1;
	rec_word_t           key_pool [KEY_POOL];

	table_reply_checker  table_check = new();

	keyed_record_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.key_low    (key_low),
		.key_high   (key_high),
		.value_low  (value_low),
		.value_high (value_high),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.found_low  (found_low),
		.found_high (found_high),
		.fill_level (fill_level)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stalls at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watch both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				table_check.log_request(cmd, {key_high, key_low}, {value_high, value_low});
			if (out_valid && out_ready)
				table_check.match_reply(ok, found_low, found_high, fill_level);
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: timeout after %0d cycles", cycle_count);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic rec_word_t random_word();
		return {8'($urandom), $urandom, $urandom};
	endfunction

	// New key set: short zero-padded strings up to the full nine bytes
	function automatic void refresh_keys();
		int unsigned len;
		for (int i = 0; i < KEY_POOL; i++) begin
			len         = $urandom_range(1, 9);
			key_pool[i] = random_word() & ({WORD_W{1'b1}} >> (8 * (9 - len)));
		end
	endfunction

	// Mostly pool keys so lookups hit; some near misses and strangers
	function automatic rec_word_t pick_key();
		rec_word_t   k;
		int unsigned r;
		r = $urandom_range(99);
		k = key_pool[$urandom_range(KEY_POOL - 1)];
		if (r >= 90)
			k = random_word();
		else if (r >= 80)
			k[$urandom_range(WORD_W - 1)] ^= 1'b1;
		return k;
	endfunction

	// Present one item and hold it until taken
	task automatic send_op(input logic [CMD_W-1:0] op, input rec_word_t k, input rec_word_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		key_low    <= k[LOW_W-1:0];
		key_high   <= k[WORD_W-1:LOW_W];
		value_low  <= v[LOW_W-1:0];
		value_high <= v[WORD_W-1:LOW_W];
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Hold off the sender until every reply is back
	task automatic wait_for_replies();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (table_check.pending() != 0);
	endtask

	// Random traffic; the mix swings between filling and draining the table
	task automatic run_random(input int unsigned count);
		int unsigned       done_items;
		int unsigned       r;
		logic [CMD_W-1:0]  op;
		done_items = 0;
		while (done_items < count) begin
			if (table_check.held >= TABLE_DEPTH && $urandom_range(3) == 0)
				growing = 1'b0;
			else if (table_check.held == 0)
				growing = 1'b1;
			r = $urandom_range(99);
			if (growing)
				op = (r < 55) ? CMD_APPEND : (r < 75) ? CMD_FIND :
				     (r < 96) ? CMD_DELETE : CMD_SPARE;
			else
				op = (r < 20) ? CMD_APPEND : (r < 45) ? CMD_FIND :
				     (r < 96) ? CMD_DELETE : CMD_SPARE;
			send_op(op, pick_key(), random_word());
			if (op != CMD_SPARE)
				done_items++;
			if ($urandom_range(149) == 0)
				wait_for_replies();
		end
	endtask

	initial begin
		rec_word_t key_text;
		rec_word_t val_a;
		key_text = 72'h00_0000_0000_0063_6261;  // "abc"
		val_a    = random_word();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, duplicates, shifts, near misses
		send_op(CMD_FIND,   '0, '1);
		send_op(CMD_DELETE, '1, '0);
		send_op(CMD_SPARE,  '1, '1);
		send_op(CMD_APPEND, '0, '1);
		send_op(CMD_APPEND, '1, '0);
		send_op(CMD_APPEND, '0, val_a);
		send_op(CMD_APPEND, key_text, random_word());
		send_op(CMD_FIND,   '0, '0);
		send_op(CMD_FIND,   '1, '0);
		send_op(CMD_FIND,   {8'h01, 64'h0}, '0);
		send_op(CMD_FIND,   {8'h00, 64'h1}, '0);
		send_op(CMD_DELETE, '0, '1);
		send_op(CMD_FIND,   '0, '0);
		send_op(CMD_DELETE, '1, '0);
		send_op(CMD_SPARE,  key_text, '1);
		send_op(CMD_FIND,   key_text, '0);
		send_op(CMD_DELETE, key_text, '0);
		send_op(CMD_DELETE, key_text, '0);
		send_op(CMD_DELETE, '0, '0);
		send_op(CMD_FIND,   '0, '0);
		wait_for_replies();

		// Random phases with different idling on each side
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 76;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 76;
			end
			default: begin
				send_idle_pct  = 9;
				recv_stall_pct = 9;
			end
			endcase
			refresh_keys();
			run_random(PER_PHASE);
			wait_for_replies();
		end

		repeat (SETTLE) @(posedge clk);

		$display("tb_top: %0d items sent, %0d replies compared, peak fill %0d",
			table_check.requests, table_check.compared, table_check.peak_fill);
		$display("tb_top: %0d find hits, %0d delete hits, %0d appends refused when full",
			table_check.find_hits, table_check.delete_hits, table_check.full_refusals);
		if (table_check.errors == 0 && table_check.pending() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
